// ===== src/simd_pkg.sv =====
package simd_pkg;

    localparam int FieldLen  = 18;
    localparam int ImsiLen   = 15;
    localparam int PosW      = 5;
    localparam int StatusW   = 9;
    localparam int NibblesW  = 4 * ImsiLen;
    localparam int OutDataW  = 72;

    localparam logic [StatusW-1:0] StatusMax  = 9'd511;
    localparam logic [StatusW-1:0] SwOkFirst  = 9'h090;
    localparam logic [StatusW-1:0] SwOkSecond = 9'h000;
    localparam logic [StatusW-1:0] SwMore91   = 9'h091;
    localparam logic [StatusW-1:0] SwMore92   = 9'h092;
    localparam logic [StatusW-1:0] SwMore9f   = 9'h09f;
    localparam logic [3:0]         NibF       = 4'd15;

    typedef logic [3:0] nib_t;

    typedef enum logic [2:0] {
        OUT_OK     = 3'd0,
        OUT_FORMAT = 3'd1,
        OUT_STATUS = 3'd2,
        OUT_CHAR   = 3'd3,
        OUT_SHORT  = 3'd4,
        OUT_FPOS   = 3'd5
    } outcome_t;

    typedef struct packed {
        logic [3:0]          digit_count;
        logic [NibblesW-1:0] imsi_nibbles;
        outcome_t            outcome;
    } result_t;

endpackage

// ===== src/sim_imsi_response_decoder_unit.sv =====
// sim read-record reply decoder for the imsi elementary file
//
// s_axis takes the reply text after its tag, one character per item; tlast
// marks the final character. the text is two decimal status words (optional
// whitespace and sign, comma separated) and an optionally quoted 18-character
// field of digits and F/f.
// m_axis gives one item per reply, on the tlast character: outcome code, the
// 15 imsi digits nibble-swapped from the field, and the digit count before
// the first F. digits and count read zero unless the outcome is ok.
// path: the final character is held in the input register while a result is
// not taken, and its result is registered in the result register, which drives
// m_axis_tvalid. throughput: one character per cycle unless a final character
// waits on a held result; the parse state is a single short decode between the
// input register and the state/result registers.
// reset clears the parse state and both valid flags; the block is ready to
// accept a character in the first cycle after reset. after each result the
// parse state returns to its reset values for the next reply.
// when m_axis stalls, a held result only blocks a following final character;
// other characters keep flowing through the input register.
module sim_imsi_response_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [simd_pkg::OutDataW-1:0] m_axis_tdata, // [2:0] outcome,
                                                        // [62:3] imsi_nibbles,
                                                        // [66:63] digit_count,
                                                        // [71:67] zero
    output logic        m_axis_tlast
);

    // parse phases: 0..2 first status word, 3..5 second (before sign, after
    // sign, in digits), 6 just after second comma, 7 inside the field
    localparam logic [2:0] PH_S1_PRE  = 3'd0;
    localparam logic [2:0] PH_S1_SIGN = 3'd1;
    localparam logic [2:0] PH_S1_DIG  = 3'd2;
    localparam logic [2:0] PH_S2_PRE  = 3'd3;
    localparam logic [2:0] PH_S2_SIGN = 3'd4;
    localparam logic [2:0] PH_S2_DIG  = 3'd5;
    localparam logic [2:0] PH_OPEN    = 3'd6;
    localparam logic [2:0] PH_FIELD   = 3'd7;

    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChPlus  = 8'h2b;
    localparam logic [7:0] ChMinus = 8'h2d;
    localparam logic [7:0] ChComma = 8'h2c;
    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0d;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChUpF   = 8'h46;
    localparam logic [7:0] ChLowF  = 8'h66;

    localparam logic [simd_pkg::PosW-1:0] PosFull = simd_pkg::PosW'(simd_pkg::FieldLen);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // parse state
    logic [2:0]                    phase_reg, phase_next;
    logic [simd_pkg::StatusW-1:0]  val1_reg, val1_next;
    logic [simd_pkg::StatusW-1:0]  val2_reg, val2_next;
    logic [1:0]                    sign_reg, sign_next;
    logic [simd_pkg::PosW-1:0]     pos_reg, pos_next;
    simd_pkg::outcome_t            err_reg, err_next;
    simd_pkg::nib_t                digits_reg  [simd_pkg::FieldLen];
    simd_pkg::nib_t                digits_next [simd_pkg::FieldLen];

    // result register
    logic                          out_valid_reg;
    logic [simd_pkg::OutDataW-1:0] out_data_reg;

    logic               proceed;
    logic [7:0]         c;
    logic               is_digit;
    logic               is_ws;
    logic               second;
    logic               sub_pre;
    logic               sub_dig;
    logic [simd_pkg::StatusW-1:0] val_cur;
    logic [12:0]        val_acc;
    logic [simd_pkg::StatusW-1:0] val_sat;
    logic               neg1;
    logic               neg2;
    logic               status_ok;
    logic               take_field;
    simd_pkg::outcome_t final_outcome;
    simd_pkg::result_t  result;

    // a final character waits only while a result is held and not taken
    assign proceed       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proceed;

    assign c        = in_char_reg;
    assign is_digit = (c >= ChZero) && (c <= ChNine);
    assign is_ws    = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    assign second   = (phase_reg >= PH_S2_PRE);
    assign sub_pre  = (phase_reg == PH_S1_PRE) || (phase_reg == PH_S2_PRE);
    assign sub_dig  = (phase_reg == PH_S1_DIG) || (phase_reg == PH_S2_DIG);
    assign val_cur  = second ? val2_reg : val1_reg;

    // value * 10 + digit, saturating at 511
    assign val_acc = {1'b0, val_cur, 3'b000} + {3'b000, val_cur, 1'b0} + {9'd0, c[3:0]};
    assign val_sat = (val_acc > {4'd0, simd_pkg::StatusMax}) ?
                     simd_pkg::StatusMax : val_acc[simd_pkg::StatusW-1:0];

    // minus zero counts as zero
    assign neg1 = sign_reg[0] && (val1_reg != '0);
    assign neg2 = sign_reg[1] && (val2_reg != '0);
    assign status_ok = !neg1 &&
        (((val1_reg == simd_pkg::SwOkFirst) && (val2_reg == simd_pkg::SwOkSecond) && !neg2) ||
         (val1_reg == simd_pkg::SwMore91) || (val1_reg == simd_pkg::SwMore92) ||
         (val1_reg == simd_pkg::SwMore9f));

    always_comb
    begin
        phase_next  = phase_reg;
        val1_next   = val1_reg;
        val2_next   = val2_reg;
        sign_next   = sign_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        digits_next = digits_reg;
        take_field  = 1'b0;

        // the first error latches and everything after it is ignored
        if (err_reg == simd_pkg::OUT_OK)
        begin
            if (c == ChNul)
            begin
                if (phase_reg != PH_FIELD)
                begin
                    err_next = simd_pkg::OUT_FORMAT;
                end
                else if (pos_reg < PosFull)
                begin
                    err_next = simd_pkg::OUT_SHORT;
                end
            end
            else if (phase_reg < PH_OPEN)
            begin
                if (sub_pre && is_ws)
                begin
                    phase_next = phase_reg;
                end
                else if (sub_pre && ((c == ChPlus) || (c == ChMinus)))
                begin
                    if (c == ChMinus)
                    begin
                        sign_next[second] = 1'b1;
                    end
                    phase_next = second ? PH_S2_SIGN : PH_S1_SIGN;
                end
                else if (is_digit)
                begin
                    if (second)
                    begin
                        val2_next = val_sat;
                    end
                    else
                    begin
                        val1_next = val_sat;
                    end
                    phase_next = second ? PH_S2_DIG : PH_S1_DIG;
                end
                else if (sub_dig && (c == ChComma))
                begin
                    phase_next = second ? PH_OPEN : PH_S2_PRE;
                end
                else
                begin
                    err_next = simd_pkg::OUT_FORMAT;
                end
            end
            else
            begin
                take_field = 1'b1;
                if (phase_reg == PH_OPEN)
                begin
                    phase_next = PH_FIELD;
                    if (!status_ok)
                    begin
                        err_next   = simd_pkg::OUT_STATUS;
                        take_field = 1'b0;
                    end
                    else if (c == ChQuote)
                    begin
                        // opening quote is skipped
                        take_field = 1'b0;
                    end
                end
                // characters past the field end are ignored
                if (take_field && (pos_reg < PosFull))
                begin
                    if (is_digit)
                    begin
                        digits_next[pos_reg] = c[3:0];
                        pos_next = pos_reg + 1'b1;
                    end
                    else if ((c == ChUpF) || (c == ChLowF))
                    begin
                        digits_next[pos_reg] = simd_pkg::NibF;
                        pos_next = pos_reg + 1'b1;
                    end
                    else if (c == ChQuote)
                    begin
                        err_next = simd_pkg::OUT_SHORT;
                    end
                    else
                    begin
                        err_next = simd_pkg::OUT_CHAR;
                    end
                end
            end
        end
    end

    // end-of-text checks on the state after the final character
    always_comb
    begin
        final_outcome = err_next;
        if ((final_outcome == simd_pkg::OUT_OK) && (phase_next != PH_FIELD))
        begin
            final_outcome = simd_pkg::OUT_FORMAT;
        end
        if ((final_outcome == simd_pkg::OUT_OK) && (pos_next < PosFull))
        begin
            final_outcome = simd_pkg::OUT_SHORT;
        end
    end

    simd_imsi_pack u_pack (
        .outcome_in   (final_outcome),
        .field_digits (digits_next),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_last_reg   <= 1'b0;
            phase_reg     <= PH_S1_PRE;
            val1_reg      <= '0;
            val2_reg      <= '0;
            sign_reg      <= '0;
            pos_reg       <= '0;
            err_reg       <= simd_pkg::OUT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
                in_last_reg  <= s_axis_tlast;
            end

            if (proceed)
            begin
                if (in_last_reg)
                begin
                    // reply done: back to the reset state for the next one
                    phase_reg <= PH_S1_PRE;
                    val1_reg  <= '0;
                    val2_reg  <= '0;
                    sign_reg  <= '0;
                    pos_reg   <= '0;
                    err_reg   <= simd_pkg::OUT_OK;
                end
                else
                begin
                    phase_reg <= phase_next;
                    val1_reg  <= val1_next;
                    val2_reg  <= val2_next;
                    sign_reg  <= sign_next;
                    pos_reg   <= pos_next;
                    err_reg   <= err_next;
                end
            end

            if (proceed && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
        end
        if (proceed)
        begin
            digits_reg <= digits_next;
        end
        if (proceed && in_last_reg)
        begin
            out_data_reg <= {5'd0, result};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = 1'b1;

endmodule

// ===== src/simd_imsi_pack.sv =====
module simd_imsi_pack (
    input  simd_pkg::outcome_t outcome_in,
    input  simd_pkg::nib_t     field_digits [simd_pkg::FieldLen],
    output simd_pkg::result_t  result
);

    simd_pkg::nib_t              imsi_d [simd_pkg::ImsiLen];
    logic [simd_pkg::ImsiLen-1:0] is_f;
    logic [simd_pkg::ImsiLen:0]   f_seen;
    logic                         misplaced;
    logic [3:0]                   count;
    logic [simd_pkg::NibblesW-1:0] nibbles;

    // nibble swap: digit 0 from position 2, then pairs (5,4) (7,6) ...
    always_comb
    begin
        imsi_d[0] = field_digits[2];
        for (int i = 1; i < 8; i++)
        begin
            imsi_d[2*i-1] = field_digits[2*i+3];
            imsi_d[2*i]   = field_digits[2*i+2];
        end
    end

    always_comb
    begin
        f_seen[0] = 1'b0;
        misplaced = 1'b0;
        for (int i = 0; i < simd_pkg::ImsiLen; i++)
        begin
            is_f[i]     = (imsi_d[i] == simd_pkg::NibF);
            f_seen[i+1] = f_seen[i] | is_f[i];
            misplaced   = misplaced | (f_seen[i] & ~is_f[i]);
            nibbles[4*i +: 4] = imsi_d[i];
        end
        // index of the first F, 15 when there is none
        count = 4'(simd_pkg::ImsiLen);
        for (int i = simd_pkg::ImsiLen - 1; i >= 0; i--)
        begin
            if (is_f[i])
            begin
                count = 4'(i);
            end
        end
    end

    always_comb
    begin
        result.outcome      = outcome_in;
        result.imsi_nibbles = '0;
        result.digit_count  = '0;
        if (outcome_in == simd_pkg::OUT_OK)
        begin
            if (misplaced)
            begin
                result.outcome = simd_pkg::OUT_FPOS;
            end
            else
            begin
                result.imsi_nibbles = nibbles;
                result.digit_count  = count;
            end
        end
    end

endmodule
